[sv/pms_pkg.sv]
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants for the PID speed/position controller
// Widths of the data path, register indexes, reset values and the
// structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Field widths
  localparam int DATA_W     = 24;  // target and feedback
  localparam int OFF_W      = 16;  // speed mode offset
  localparam int GAIN_W     = 16;  // Q8.8 gains
  localparam int FRAC_W     = 8;   // gain fraction bits
  localparam int LIM_W      = 16;  // integral and drive limits
  localparam int TLIM_W     = 15;  // target limit
  localparam int DRIVE_W    = 17;  // signed drive
  localparam int DUTY_W     = 16;  // PWM compare values

  // Internal widths, sized to the value ranges
  localparam int ERR_W      = DATA_W + 1;           // target' - feedback
  localparam int DIFF_W     = ERR_W + 1;            // err - previous err
  localparam int PROD_W     = GAIN_W + 1 + ERR_W;   // gain * err
  localparam int DPROD_W    = GAIN_W + 1 + DIFF_W;  // gain * diff
  localparam int INTEG_W    = LIM_W + FRAC_W + 1;   // clamped scaled integral
  localparam int ACC_W      = PROD_W + 1;           // integral + gain_i * err
  localparam int PSUM_W     = DPROD_W + 1;          // P + D
  localparam int SUM_W      = PSUM_W + 1;           // P + I + D
  localparam int SHR_W      = SUM_W - FRAC_W;       // sum after the Q8.8 shift

  // Configuration port
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LIMIT   = 3'd6;

  localparam logic MODE_SPEED    = 1'b0;
  localparam logic MODE_POSITION = 1'b1;

  localparam logic [LIM_W-1:0]  RST_INTEGRAL_LIMIT = 16'd1000;
  localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT    = 16'd999;
  localparam logic [TLIM_W-1:0] RST_TARGET_LIMIT   = 15'd180;

  // Configuration register set
  typedef struct packed {
    logic              mode;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  drive_limit;
    logic [TLIM_W-1:0] target_limit;
  } cfg_t;

  // Error stage to product stage
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic                     tnn;   // adjusted target is non-negative
  } front_t;

  // Accumulate stage to output stage
  typedef struct packed {
    logic signed [PSUM_W-1:0]  psum;  // P + D terms
    logic signed [INTEG_W-1:0] integ; // scaled integral for this item
    logic                      tnn;
  } calc_t;

endpackage

[sv/pms_sample_if.sv]
// ----------------------------------------------------------------------------
// pms_sample_if: sample channel
// Valid/ready channel carrying target, feedback and offset.
// ----------------------------------------------------------------------------
interface pms_sample_if;
  import pms_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] feedback;
  logic signed [OFF_W-1:0]  offset;

  modport source (output valid, output target, output feedback, output offset,
                  input ready);
  modport sink   (input valid, input target, input feedback, input offset,
                  output ready);
endinterface

[sv/pms_command_if.sv]
// ----------------------------------------------------------------------------
// pms_command_if: command channel
// Valid/ready channel carrying the drive and the two PWM compare values.
// ----------------------------------------------------------------------------
interface pms_command_if;
  import pms_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic [DUTY_W-1:0]         duty_forward;
  logic [DUTY_W-1:0]         duty_reverse;

  modport source (output valid, output drive, output duty_forward,
                  output duty_reverse, input ready);
  modport sink   (input valid, input drive, input duty_forward,
                  input duty_reverse, output ready);
endinterface

[sv/pid_motor_speed_position_top.sv]
// ----------------------------------------------------------------------------
// pid_motor_speed_position_top: positional PID with anti-windup and PWM split
// Throughput: one sample per cycle unless the command is stalled; six
// register stages, each with its own valid bit, so a stalled command only
// fills the stages behind it.
// Reset: clears all valid bits, the integral and the previous error, and
// loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
module pid_motor_speed_position_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pms_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_data,
  pms_sample_if.sink                     sample,
  pms_command_if.source                  command
);
  import pms_pkg::*;

  cfg_t   cfg;
  logic   f_valid, f_ready;
  front_t f_data;
  logic   c_valid, c_ready;
  calc_t  c_data;

  // Configuration registers
  pms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Capture, error, derivative difference
  pms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .sample   (sample),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_data  (f_data)
  );

  // Products and integral
  pms_calc u_calc (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  // Sum, clamp and command register
  pms_out u_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (c_valid),
    .up_ready (c_ready),
    .up_data  (c_data),
    .command  (command)
  );

endmodule

[sv/pms_cfg.sv]
// ----------------------------------------------------------------------------
// pms_cfg: configuration registers
// Write-only register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module pms_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pms_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [pms_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pms_pkg::cfg_t                      cfg
);
  import pms_pkg::*;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_SPEED;
      cfg.gain_p         <= '0;
      cfg.gain_i         <= '0;
      cfg.gain_d         <= '0;
      cfg.integral_limit <= RST_INTEGRAL_LIMIT;
      cfg.drive_limit    <= RST_DRIVE_LIMIT;
      cfg.target_limit   <= RST_TARGET_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:           cfg.mode           <= cfg_data[0];
        REG_GAIN_P:         cfg.gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:         cfg.gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:         cfg.gain_d         <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[LIM_W-1:0];
        REG_DRIVE_LIMIT:    cfg.drive_limit    <= cfg_data[LIM_W-1:0];
        REG_TARGET_LIMIT:   cfg.target_limit   <= cfg_data[TLIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/pms_front.sv]
// ----------------------------------------------------------------------------
// pms_front: input register, error and error difference
// Three stages: sample capture, target clamp and error, derivative
// difference against the previous error.
// ----------------------------------------------------------------------------
module pms_front (
  input  logic             clk,
  input  logic             rst,
  input  pms_pkg::cfg_t    cfg,
  pms_sample_if.sink       sample,
  output logic             dn_valid,
  input  logic             dn_ready,
  output pms_pkg::front_t  dn_data
);
  import pms_pkg::*;

  logic                     va, vb, vc;
  logic                     ra, rb, rc;
  logic signed [DATA_W-1:0] a_target;
  logic signed [DATA_W-1:0] a_feedback;
  logic signed [OFF_W-1:0]  a_offset;
  logic signed [ERR_W-1:0]  b_err;
  logic                     b_tnn;
  front_t                   c_data;
  logic signed [ERR_W-1:0]  prev_error;

  logic signed [DATA_W-1:0] tl_pos;
  logic signed [DATA_W-1:0] tl_neg;
  logic signed [DATA_W-1:0] tgt_clamp;
  logic signed [ERR_W-1:0]  tgt_adj;
  logic signed [ERR_W-1:0]  err_next;
  logic signed [DIFF_W-1:0] diff_next;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign rc           = !vc || dn_ready;
  assign rb           = !vb || rc;
  assign ra           = !va || rb;
  assign sample.ready = ra;

  // Target clamp (speed mode), offset and error
  always_comb begin
    tl_pos    = DATA_W'($signed({1'b0, cfg.target_limit}));
    tl_neg    = -tl_pos;
    tgt_clamp = (a_target < tl_neg) ? tl_neg :
                (a_target > tl_pos) ? tl_pos : a_target;
    if (cfg.mode == MODE_POSITION) begin
      tgt_adj = ERR_W'(a_target);
    end else begin
      tgt_adj = ERR_W'(tgt_clamp) + ERR_W'(a_offset);
    end
    err_next  = tgt_adj - ERR_W'(a_feedback);
    diff_next = DIFF_W'(b_err) - DIFF_W'(prev_error);
  end

  // Valid bits and previous error
  always_ff @(posedge clk) begin
    if (rst) begin
      va         <= 1'b0;
      vb         <= 1'b0;
      vc         <= 1'b0;
      prev_error <= '0;
    end else begin
      if (ra) va <= sample.valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      // previous error advances once per item, as it leaves stage B
      if (rc && vb) prev_error <= b_err;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ra && sample.valid) begin
      a_target   <= sample.target;
      a_feedback <= sample.feedback;
      a_offset   <= sample.offset;
    end
    if (rb && va) begin
      b_err <= err_next;
      b_tnn <= !tgt_adj[ERR_W-1];
    end
    if (rc && vb) begin
      c_data.err  <= b_err;
      c_data.diff <= diff_next;
      c_data.tnn  <= b_tnn;
    end
  end

  assign dn_valid = vc;
  assign dn_data  = c_data;

endmodule

[sv/pms_calc.sv]
// ----------------------------------------------------------------------------
// pms_calc: gain products and integral accumulation
// One stage of three parallel multiplies, then the clamped integral
// update and the P + D sum.
// ----------------------------------------------------------------------------
module pms_calc (
  input  logic             clk,
  input  logic             rst,
  input  pms_pkg::cfg_t    cfg,
  input  logic             up_valid,
  output logic             up_ready,
  input  pms_pkg::front_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output pms_pkg::calc_t   dn_data
);
  import pms_pkg::*;

  logic                      vd, ve;
  logic                      rd, re;
  logic signed [PROD_W-1:0]  d_pp;
  logic signed [PROD_W-1:0]  d_pi;
  logic signed [DPROD_W-1:0] d_pd;
  logic                      d_tnn;
  logic signed [PSUM_W-1:0]  e_psum;
  logic                      e_tnn;
  logic signed [INTEG_W-1:0] integral;

  logic signed [PROD_W-1:0]  pp_next;
  logic signed [PROD_W-1:0]  pi_next;
  logic signed [DPROD_W-1:0] pd_next;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   ilim;
  logic signed [ACC_W-1:0]   ilim_neg;
  logic signed [INTEG_W-1:0] integral_next;

  assign re       = !ve || dn_ready;
  assign rd       = !vd || re;
  assign up_ready = rd;

  // Gain products
  always_comb begin
    pp_next = PROD_W'($signed({1'b0, cfg.gain_p})) * PROD_W'($signed(up_data.err));
    pi_next = PROD_W'($signed({1'b0, cfg.gain_i})) * PROD_W'($signed(up_data.err));
    pd_next = DPROD_W'($signed({1'b0, cfg.gain_d})) * DPROD_W'($signed(up_data.diff));
  end

  // Integral update with saturation at +/- limit in Q8.8
  always_comb begin
    acc      = ACC_W'(integral) + ACC_W'(d_pi);
    ilim     = ACC_W'($signed({1'b0, cfg.integral_limit, {FRAC_W{1'b0}}}));
    ilim_neg = -ilim;
    if (acc > ilim) begin
      integral_next = INTEG_W'(ilim);
    end else if (acc < ilim_neg) begin
      integral_next = INTEG_W'(ilim_neg);
    end else begin
      integral_next = INTEG_W'(acc);
    end
  end

  // Valid bits and integral state
  always_ff @(posedge clk) begin
    if (rst) begin
      vd       <= 1'b0;
      ve       <= 1'b0;
      integral <= '0;
    end else begin
      if (rd) vd <= up_valid;
      if (re) ve <= vd;
      if (re && vd) integral <= integral_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd && up_valid) begin
      d_pp  <= pp_next;
      d_pi  <= pi_next;
      d_pd  <= pd_next;
      d_tnn <= up_data.tnn;
    end
    if (re && vd) begin
      e_psum <= PSUM_W'(d_pp) + PSUM_W'(d_pd);
      e_tnn  <= d_tnn;
    end
  end

  // The integral register holds this item's value until the next item enters
  assign dn_valid      = ve;
  assign dn_data.psum  = e_psum;
  assign dn_data.integ = integral;
  assign dn_data.tnn   = e_tnn;

endmodule

[sv/pms_out.sv]
// ----------------------------------------------------------------------------
// pms_out: final sum, drive clamp and PWM split
// Adds the integral, floors by the gain fraction, clamps the drive by
// mode and direction, and registers the command.
// ----------------------------------------------------------------------------
module pms_out (
  input  logic            clk,
  input  logic            rst,
  input  pms_pkg::cfg_t   cfg,
  input  logic            up_valid,
  output logic            up_ready,
  input  pms_pkg::calc_t  up_data,
  pms_command_if.source   command
);
  import pms_pkg::*;

  logic                      rf;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SHR_W-1:0]   shr;
  logic signed [SHR_W-1:0]   dmax;
  logic signed [SHR_W-1:0]   lo;
  logic signed [SHR_W-1:0]   hi;
  logic signed [SHR_W-1:0]   drv;
  logic signed [DRIVE_W-1:0] drive_next;
  logic signed [DRIVE_W-1:0] drive_neg;

  assign rf       = !command.valid || command.ready;
  assign up_ready = rf;

  // Sum and flooring shift
  always_comb begin
    sum = SUM_W'($signed(up_data.psum)) + SUM_W'($signed(up_data.integ));
    shr = SHR_W'(sum >>> FRAC_W);
  end

  // Drive bounds: one-sided in speed mode, symmetric in position mode
  always_comb begin
    dmax = SHR_W'($signed({1'b0, cfg.drive_limit}));
    if (cfg.mode == MODE_POSITION) begin
      lo = -dmax;
      hi = dmax;
    end else if (up_data.tnn) begin
      lo = '0;
      hi = dmax;
    end else begin
      lo = -dmax;
      hi = '0;
    end
    drv        = (shr < lo) ? lo : (shr > hi) ? hi : shr;
    drive_next = DRIVE_W'(drv);
    drive_neg  = -drive_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (rf) begin
      command.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rf && up_valid) begin
      command.drive <= drive_next;
      if (drive_next[DRIVE_W-1]) begin
        command.duty_forward <= '0;
        command.duty_reverse <= drive_neg[DUTY_W-1:0];
      end else begin
        command.duty_forward <= drive_next[DUTY_W-1:0];
        command.duty_reverse <= '0;
      end
    end
  end

endmodule

[sv/pms_checker.sv]
// ----------------------------------------------------------------------------
// pms_checker: port-level checks for the PID controller
// Watches the command channel for reset behavior, PWM split rules and stall holding.
// ----------------------------------------------------------------------------
module pms_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          command_valid,
  input logic                          command_ready,
  input logic [pms_pkg::DRIVE_W-1:0]   drive,
  input logic [pms_pkg::DUTY_W-1:0]    duty_forward,
  input logic [pms_pkg::DUTY_W-1:0]    duty_reverse
);
  import pms_pkg::*;

  // No command right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !command_valid)
    else $error("command valid right after reset");

  // Only one direction is driven
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    command_valid |-> (duty_forward == '0 || duty_reverse == '0))
    else $error("both PWM duties nonzero");

  // Forward duty follows a non-negative drive
  a_forward: assert property (@(posedge clk) disable iff (rst)
    command_valid && !drive[DRIVE_W-1] |-> duty_forward == drive[DUTY_W-1:0])
    else $error("forward duty differs from drive");

  // Reverse duty is the magnitude of a negative drive
  a_reverse: assert property (@(posedge clk) disable iff (rst)
    command_valid && drive[DRIVE_W-1] |->
      duty_reverse == (~drive[DUTY_W-1:0] + 16'd1))
    else $error("reverse duty differs from drive magnitude");

  // A stalled command holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    command_valid && !command_ready |=> command_valid && $stable(drive))
    else $error("stalled command changed");

endmodule

bind pid_motor_speed_position_top pms_checker u_pms_checker (
  .clk           (clk),
  .rst           (rst),
  .command_valid (command.valid),
  .command_ready (command.ready),
  .drive         (command.drive),
  .duty_forward  (command.duty_forward),
  .duty_reverse  (command.duty_reverse)
);

[tb/pms_drive_checker.sv]
// ----------------------------------------------------------------------------
// pms_drive_checker: command predictor and comparator
// Follows the configuration writes, predicts a command for every sample
// transfer and compares each command transfer, field by field, against the
// oldest prediction. It reports the failure count and the commands in flight.
// ----------------------------------------------------------------------------
module pms_drive_checker
  import pms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pms_sample_if                 sample,
  pms_command_if                command,
  output int                    errors,
  output int                    pending
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [DUTY_W-1:0]         duty_fwd;
    logic [DUTY_W-1:0]         duty_rev;
  } command_t;

  // Shadow of the register file and of the loop state
  cfg_t     cfg_q;
  longint   integ_sum;   // scaled integral, FRAC_W fraction bits
  longint   last_err;
  command_t cmd_q[$];
  int       fail_cnt;

  function automatic longint bound(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One PID step: updates the loop state and returns the command it yields
  function automatic command_t next_command(input logic signed [DATA_W-1:0] tgt,
                                            input logic signed [DATA_W-1:0] fb,
                                            input logic signed [OFF_W-1:0]  off);
    longint   setp, tl, err, ilim, sum, drv, dmax, mag;
    command_t c;
    setp = longint'(tgt);
    if (cfg_q.mode == MODE_SPEED) begin
      tl   = longint'(cfg_q.target_limit);
      setp = bound(setp, -tl, tl) + longint'(off);
    end
    err  = setp - longint'(fb);
    ilim = longint'(cfg_q.integral_limit) <<< FRAC_W;
    integ_sum = bound(integ_sum + longint'(cfg_q.gain_i) * err, -ilim, ilim);
    sum  = longint'(cfg_q.gain_p) * err + integ_sum
         + longint'(cfg_q.gain_d) * (err - last_err);
    drv  = sum >>> FRAC_W;  // floor
    dmax = longint'(cfg_q.drive_limit);
    // speed loop never drives against the sign of the setpoint
    if (cfg_q.mode == MODE_POSITION) drv = bound(drv, -dmax, dmax);
    else if (setp >= 0)              drv = bound(drv, 0, dmax);
    else                             drv = bound(drv, -dmax, 0);
    last_err = err;
    mag = -drv;
    c.drive    = drv[DRIVE_W-1:0];
    c.duty_fwd = (drv >= 0) ? drv[DUTY_W-1:0] : '0;
    c.duty_rev = (drv < 0)  ? mag[DUTY_W-1:0] : '0;
    return c;
  endfunction

  always @(posedge clk) begin : monitor
    command_t got, want;
    if (rst) begin
      cfg_q                = '0;
      cfg_q.mode           = MODE_SPEED;
      cfg_q.integral_limit = RST_INTEGRAL_LIMIT;
      cfg_q.drive_limit    = RST_DRIVE_LIMIT;
      cfg_q.target_limit   = RST_TARGET_LIMIT;
      integ_sum = 0;
      last_err  = 0;
      cmd_q.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:           cfg_q.mode           = cfg_data[0];
          REG_GAIN_P:         cfg_q.gain_p         = cfg_data;
          REG_GAIN_I:         cfg_q.gain_i         = cfg_data;
          REG_GAIN_D:         cfg_q.gain_d         = cfg_data;
          REG_INTEGRAL_LIMIT: cfg_q.integral_limit = cfg_data;
          REG_DRIVE_LIMIT:    cfg_q.drive_limit    = cfg_data;
          REG_TARGET_LIMIT:   cfg_q.target_limit   = cfg_data[TLIM_W-1:0];
          default: ;
        endcase
      end

      if (sample.valid && sample.ready)
        cmd_q.push_back(next_command(sample.target, sample.feedback, sample.offset));

      // compare the command transfer against the oldest prediction
      if (command.valid && command.ready) begin
        got.drive    = command.drive;
        got.duty_fwd = command.duty_forward;
        got.duty_rev = command.duty_reverse;
        if (cmd_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("unexpected command at %0t: drive %0d fwd %0d rev %0d",
                     $time, got.drive, got.duty_fwd, got.duty_rev);
        end else begin
          want = cmd_q.pop_front();
          if (got != want) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
              $display("command mismatch at %0t: drive %0d/%0d fwd %0d/%0d rev %0d/%0d (exp/got)",
                       $time, want.drive, got.drive, want.duty_fwd, got.duty_fwd,
                       want.duty_rev, got.duty_rev);
          end
        end
      end
    end
    errors  <= fail_cnt;
    pending <= cmd_q.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the PID speed/position controller
// Directed samples at the field and register extremes, then randomized
// phases with new settings and varying sample gaps and command stalls,
// including a long command hold-off. Checking is done in pms_drive_checker.
// ----------------------------------------------------------------------------
module tb;
  import pms_pkg::*;

  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 75;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_req;
  int                    src_idle;
  int                    sink_stall;
  int                    errors;
  int                    pending;

  pms_sample_if  sample_ch ();
  pms_command_if command_ch ();

  pid_motor_speed_position_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .command   (command_ch)
  );

  pms_drive_checker u_drive_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .command   (command_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Command sink: random stalls, or a long hold-off on request
  initial begin
    command_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        command_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        command_ch.ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (command_ch.valid && command_ch.ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // One sample transfer, after a random gap
  task automatic put_sample(input logic signed [DATA_W-1:0] tgt,
                            input logic signed [DATA_W-1:0] fb,
                            input logic signed [OFF_W-1:0]  off);
    while ($urandom_range(99) < src_idle) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.target   <= tgt;
    sample_ch.feedback <= fb;
    sample_ch.offset   <= off;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Mostly plausible loop traffic, some full-range noise
  task automatic put_random_sample();
    int kind, base;
    logic signed [DATA_W-1:0] tgt, fb;
    logic signed [OFF_W-1:0]  off;
    kind = $urandom_range(9);
    if (kind == 0) begin
      tgt = DATA_W'($urandom());
      fb  = DATA_W'($urandom());
      off = OFF_W'($urandom());
    end else if (kind == 1) begin
      tgt = DATA_W'($urandom());
      fb  = DATA_W'(int'($urandom_range(511)) - 256);
      off = OFF_W'(int'($urandom_range(511)) - 256);
    end else begin
      base = int'($urandom_range(8191)) - 4096;
      tgt  = DATA_W'(base);
      fb   = DATA_W'(base + int'($urandom_range(400)) - 200);
      off  = OFF_W'(int'($urandom_range(100)) - 50);
    end
    put_sample(tgt, fb, off);
  endtask

  // Stop offering samples until every command has come out
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Full register set; the trailing write to an unused index must be ignored
  task automatic load_config(input logic [CFG_DATA_W-1:0] mode_word,
                             input logic [CFG_DATA_W-1:0] kp, ki, kd,
                             input logic [CFG_DATA_W-1:0] ilim, dlim, tlim);
    write_reg(REG_MODE, mode_word);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_INTEGRAL_LIMIT, ilim);
    write_reg(REG_DRIVE_LIMIT, dlim);
    write_reg(REG_TARGET_LIMIT, tlim);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(16'h0100));
      2:       return CFG_DATA_W'($urandom_range(16'h0800));
      default: return CFG_DATA_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] mode_word, ilim, dlim, tlim;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    hold_req            = 1'b0;
    src_idle            = 0;
    sink_stall          = 0;
    sample_ch.valid     = 1'b0;
    sample_ch.target    = '0;
    sample_ch.feedback  = '0;
    sample_ch.offset    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Speed loop: target clamp, offset extremes, sign-dependent drive clamp
    load_config({15'h7FFF, MODE_SPEED}, 16'h0100, 16'h0020, 16'h0040,
                16'd1000, 16'd999, 16'd180);
    put_sample(24'sd0, 24'sd0, 16'sd0);
    put_sample(24'sd180, 24'sd0, 16'sd0);
    put_sample(-24'sd180, 24'sd0, 16'sd0);
    put_sample(24'sh7FFFFF, 24'sd0, 16'sd0);
    put_sample(24'sh800000, 24'sd0, 16'sd0);
    put_sample(24'sd100, 24'sd0, 16'sh7FFF);
    put_sample(-24'sd100, 24'sd0, 16'sh8000);
    put_sample(24'sd0, 24'sh7FFFFF, 16'sd0);
    put_sample(24'sd0, 24'sh800000, 16'sd0);
    put_sample(24'sd5, 24'sd7, 16'sd0);

    // Position loop, all gains and limits at maximum, extra data bits set
    settle();
    load_config({15'h7FFF, MODE_POSITION}, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF);
    put_sample(24'sh7FFFFF, 24'sh800000, 16'sh7FFF);
    put_sample(24'sh800000, 24'sh7FFFFF, 16'sh8000);
    put_sample(24'sh7FFFFF, 24'sh800000, 16'sd0);
    put_sample(24'sd1, 24'sd0, 16'sd0);
    put_sample(-24'sd1, 24'sd0, 16'sd0);

    // Zero integral gain holds a re-clamped integral; zero drive limit
    settle();
    load_config({15'h0000, MODE_POSITION}, 16'h0180, 16'h0000, 16'h0000,
                16'd1000, 16'd0, 16'd180);
    put_sample(24'sd1000, 24'sd0, 16'sd0);
    put_sample(-24'sd1000, 24'sd0, 16'sd0);
    put_sample(24'sd3, 24'sd0, 16'sd0);

    // Flooring of small negative sums, zero integral and target limits
    settle();
    load_config({15'h0000, MODE_SPEED}, 16'd3, 16'h0100, 16'h0000,
                16'd0, 16'hFFFF, 16'd0);
    put_sample(-24'sd1, 24'sd0, 16'sd0);
    put_sample(24'sd0, 24'sd0, -16'sd5);
    put_sample(24'sd0, 24'sd2, 16'sd1);
    put_sample(24'sd7, 24'sd0, 16'sd0);

    // Randomized phases, rotating through the idle/stall mixes
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 70; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 70; end
        default: begin src_idle = 34; sink_stall = 34; end
      endcase
      mode_word = CFG_DATA_W'($urandom());
      ilim = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                  : $urandom_range(4000));
      dlim = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                                  : $urandom_range(2000));
      tlim = CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(16'h7FFF)
                                                  : $urandom_range(2000));
      if (p == 2)
        load_config({15'h0000, MODE_POSITION}, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'h7FFF);
      else if (p == 6)
        load_config(mode_word, pick_gain(), pick_gain(), pick_gain(), 16'd0, dlim, 16'd0);
      else
        load_config(mode_word, pick_gain(), pick_gain(), pick_gain(), ilim, dlim, tlim);
      // long command hold-off while samples keep coming
      if (p == 1) hold_req <= 1'b1;
      repeat (PHASE_ITEMS) put_random_sample();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
